// ----- hw/rtl/lrgd_pkg.sv -----
// Shared constants, types and state codes for the gradient descent trainer.
package lrgd_pkg;

	localparam int MAX_FEATURES = 16;
	localparam int MAX_SAMPLES  = 256;
	localparam int FI_W   = $clog2(MAX_FEATURES);
	localparam int SI_W   = $clog2(MAX_SAMPLES);
	localparam int FADR_W = SI_W + FI_W;
	localparam int MCNT_W = 9;
	localparam int NCNT_W = 5;
	localparam int LR_W   = 17;
	localparam int ITER_W = 16;
	localparam int VAL_W  = 32;
	localparam int ACC_W  = 64;
	localparam int MUL_W  = 33;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 17;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [2:0] {
		CMD_LOAD_FEATURE = 3'd0,
		CMD_LOAD_TARGET  = 3'd1,
		CMD_LOAD_WEIGHT  = 3'd2,
		CMD_LOAD_BIAS    = 3'd3,
		CMD_RUN          = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_COUNT    = 2'd0,
		REG_FEATURE_COUNT   = 2'd1,
		REG_LEARN_RATE      = 2'd2,
		REG_ITERATION_COUNT = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_DOT_RD,
		ST_DOT_MUL,
		ST_DOT_ACC,
		ST_ERR,
		ST_GRD_RD,
		ST_GRD_MUL,
		ST_GRD_ACC,
		ST_DIV_INIT,
		ST_DIV_STEP,
		ST_DIV_FIX,
		ST_STEP_LO,
		ST_STEP_HI,
		ST_STEP_UPD,
		ST_OUT
	} state_t;

endpackage

// ----- hw/rtl/lrgd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lrgd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/linear_regression_gd_trainer.sv -----
// Top level of the batch gradient descent linear regression trainer.
//
// Channel   | Dir | Signals                         | Payload
// ----------+-----+---------------------------------+-----------------------------------
// s_axis    | in  | tvalid, tready, tdata[47:0]     | cmd, sample_index, feature_index, value
// m_axis    | out | tvalid, tready, tdata[39:0], tlast | param_index, param_value; tlast = last
// cfg       | in  | valid, ready, index[1:0], data  | register write, always ready
//
// Load requests are accepted back to back while idle.
// A run request makes, per iteration, a pass over m samples and n features, with every
// multiply on the shared 33x33 multiplier and a restoring divide per parameter by the
// sample count m. Then n+1 results drain.
// s_axis_tready is low from the run request until the bias result is taken.
// Reset returns control and configuration to defaults and clears bias and accumulators; stores are undefined.
module linear_regression_gd_trainer
	import lrgd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [2:0] cmd, [10:3] sample_index, [14:11] feature_index, [46:15] value, pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [4:0] param_index, [36:5] param_value, pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data
);

	// Input field unpack
	logic [2:0]       in_cmd;
	logic [SI_W-1:0]  in_si;
	logic [FI_W-1:0]  in_fi;
	logic [VAL_W-1:0] in_val;
	assign in_cmd = s_axis_tdata[2:0];
	assign in_si  = s_axis_tdata[10:3];
	assign in_fi  = s_axis_tdata[14:11];
	assign in_val = s_axis_tdata[46:15];

	// Configuration registers
	logic [MCNT_W-1:0] sample_count_q;
	logic [NCNT_W-1:0] feature_count_q;
	logic [LR_W-1:0]   learn_rate_q;
	logic [ITER_W-1:0] iteration_count_q;

	state_t state_q, state_d;

	// Sequencer counters and run-time copies of the clamped counts
	logic [MCNT_W-1:0] m_q;
	logic [NCNT_W-1:0] n_q;
	logic [SI_W-1:0]   i_q;
	logic [NCNT_W-1:0] j_q;
	logic [ITER_W-1:0] iter_q;
	logic [5:0]        div_cnt_q;

	// Datapath registers
	logic [VAL_W-1:0]  weight_q [MAX_FEATURES];
	logic [VAL_W-1:0]  bias_q;
	logic [ACC_W-1:0]  wacc_q [MAX_FEATURES];
	logic [ACC_W-1:0]  bacc_q;
	logic [VAL_W-1:0]  dot_q;
	logic [VAL_W-1:0]  err_q;
	logic [ACC_W-1:0]  div_a_q;
	logic [MCNT_W-1:0] rem_q;
	logic              div_neg_q;
	logic [47:0]       lo_q;
	logic [2*MUL_W-1:0] prod_s1;

	logic [VAL_W-1:0] x_rdata;
	logic [VAL_W-1:0] y_rdata;

	logic in_acc, out_acc, run_req;
	logic [MUL_W-1:0] mul_a, mul_b;

	logic [FI_W-1:0] jx;
	logic            j_last, j_bias, i_last, div_last;
	logic [MCNT_W-1:0] m_eff;
	logic [NCNT_W-1:0] n_eff;
	logic [ACC_W-1:0]  div_src;
	logic [MCNT_W:0]   rem_sh;
	logic              rem_ge;
	logic [VAL_W-1:0]  step;
	logic [ACC_W-1:0]  prod_asr;
	logic [VAL_W-1:0]  out_value;

	assign jx       = j_q[FI_W-1:0];
	assign j_last   = (j_q == n_q - NCNT_W'(1));
	assign j_bias   = (j_q == n_q);
	assign i_last   = ({1'b0, i_q} == m_q - MCNT_W'(1));
	assign div_last = (div_cnt_q == 6'd63);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_acc  = m_axis_tvalid && m_axis_tready;
	assign run_req  = in_acc && (in_cmd == CMD_RUN);
	assign cfg_ready = 1'b1;

	// Clamp the counts into their legal ranges at the start of a run
	always_comb begin
		m_eff = sample_count_q;
		if (sample_count_q == '0) begin
			m_eff = MCNT_W'(1);
		end else if (sample_count_q > MCNT_W'(MAX_SAMPLES)) begin
			m_eff = MCNT_W'(MAX_SAMPLES);
		end
		n_eff = feature_count_q;
		if (feature_count_q == '0) begin
			n_eff = NCNT_W'(1);
		end else if (feature_count_q > NCNT_W'(MAX_FEATURES)) begin
			n_eff = NCNT_W'(MAX_FEATURES);
		end
	end

	assign div_src  = j_bias ? bacc_q : wacc_q[jx];
	assign rem_sh   = {rem_q, div_a_q[ACC_W-1]};
	assign rem_ge   = (rem_sh >= {1'b0, m_q});
	// Product shifted right 16 with sign fill
	assign prod_asr = {{16{prod_s1[63]}}, prod_s1[63:16]};
	// Step bits [47:16] of quotient*learn_rate from the two partial products
	assign step     = {prod_s1[15:0] + lo_q[47:32], lo_q[31:16]};
	assign out_value = j_bias ? bias_q : weight_q[jx];

	// Stores
	lrgd_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SAMPLES * MAX_FEATURES)) u_feature_ram (
		.clk   (clk),
		.we    (in_acc && (in_cmd == CMD_LOAD_FEATURE)),
		.waddr ({in_si, in_fi}),
		.wdata (in_val),
		.raddr ({i_q, jx}),
		.rdata (x_rdata)
	);

	lrgd_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SAMPLES)) u_target_ram (
		.clk   (clk),
		.we    (in_acc && (in_cmd == CMD_LOAD_TARGET)),
		.waddr (in_si),
		.wdata (in_val),
		.raddr (i_q),
		.rdata (y_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (run_req) begin
					state_d = (iteration_count_q == '0) ? ST_OUT : ST_CLR;
				end
			end
			ST_CLR:      state_d = ST_DOT_RD;
			ST_DOT_RD:   state_d = ST_DOT_MUL;
			ST_DOT_MUL:  state_d = ST_DOT_ACC;
			ST_DOT_ACC:  state_d = j_last ? ST_ERR : ST_DOT_RD;
			ST_ERR:      state_d = ST_GRD_RD;
			ST_GRD_RD:   state_d = ST_GRD_MUL;
			ST_GRD_MUL:  state_d = ST_GRD_ACC;
			ST_GRD_ACC: begin
				if (!j_last) begin
					state_d = ST_GRD_RD;
				end else if (i_last) begin
					state_d = ST_DIV_INIT;
				end else begin
					state_d = ST_DOT_RD;
				end
			end
			ST_DIV_INIT: state_d = ST_DIV_STEP;
			ST_DIV_STEP: state_d = div_last ? ST_DIV_FIX : ST_DIV_STEP;
			ST_DIV_FIX:  state_d = ST_STEP_LO;
			ST_STEP_LO:  state_d = ST_STEP_HI;
			ST_STEP_HI:  state_d = ST_STEP_UPD;
			ST_STEP_UPD: begin
				if (!j_bias) begin
					state_d = ST_DIV_INIT;
				end else if (iter_q + ITER_W'(1) == iteration_count_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_CLR;
				end
			end
			ST_OUT: begin
				if (out_acc && j_bias) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and multiplier operand select
	always_comb begin
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_DOT_MUL: begin
				mul_a = {weight_q[jx][VAL_W-1], weight_q[jx]};
				mul_b = {x_rdata[VAL_W-1], x_rdata};
			end
			ST_GRD_MUL: begin
				mul_a = {err_q[VAL_W-1], err_q};
				mul_b = {x_rdata[VAL_W-1], x_rdata};
			end
			ST_STEP_LO: begin
				mul_a = {1'b0, div_a_q[31:0]};
				mul_b = MUL_W'(learn_rate_q);
			end
			ST_STEP_HI: begin
				mul_a = MUL_W'(div_a_q[47:32]);
				mul_b = MUL_W'(learn_rate_q);
			end
			ST_OUT: m_axis_tvalid = 1'b1;
			default: begin
			end
		endcase
	end

	assign m_axis_tdata = {3'b000, out_value, j_q};
	assign m_axis_tlast = j_bias;

	// Shared multiplier with its output register
	always_ff @(posedge clk) begin
		prod_s1 <= $signed(mul_a) * $signed(mul_b);
	end

	// Control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			sample_count_q    <= MCNT_W'(1);
			feature_count_q   <= NCNT_W'(1);
			learn_rate_q      <= LR_W'(655);
			iteration_count_q <= ITER_W'(1000);
			m_q       <= MCNT_W'(1);
			n_q       <= NCNT_W'(1);
			i_q       <= '0;
			j_q       <= '0;
			iter_q    <= '0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SAMPLE_COUNT:    sample_count_q    <= cfg_data[MCNT_W-1:0];
					REG_FEATURE_COUNT:   feature_count_q   <= cfg_data[NCNT_W-1:0];
					REG_LEARN_RATE:      learn_rate_q      <= cfg_data[LR_W-1:0];
					REG_ITERATION_COUNT: iteration_count_q <= cfg_data[ITER_W-1:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (run_req) begin
						m_q    <= m_eff;
						n_q    <= n_eff;
						iter_q <= '0;
						j_q    <= '0;
					end
				end
				ST_CLR: begin
					i_q <= '0;
					j_q <= '0;
				end
				ST_DOT_ACC: j_q <= j_last ? '0 : j_q + NCNT_W'(1);
				ST_GRD_ACC: begin
					if (!j_last) begin
						j_q <= j_q + NCNT_W'(1);
					end else begin
						j_q <= '0;
						if (!i_last) begin
							i_q <= i_q + SI_W'(1);
						end
					end
				end
				ST_DIV_INIT: div_cnt_q <= '0;
				ST_DIV_STEP: div_cnt_q <= div_cnt_q + 6'd1;
				ST_STEP_UPD: begin
					if (j_bias) begin
						j_q    <= '0;
						iter_q <= iter_q + ITER_W'(1);
					end else begin
						j_q <= j_q + NCNT_W'(1);
					end
				end
				ST_OUT: begin
					if (out_acc && !j_bias) begin
						j_q <= j_q + NCNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Bias and gradient accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			bacc_q <= '0;
			for (int k = 0; k < MAX_FEATURES; k++) begin
				wacc_q[k] <= '0;
			end
		end else begin
			if (in_acc && (in_cmd == CMD_LOAD_BIAS)) begin
				bias_q <= in_val;
			end
			case (state_q)
				ST_CLR: begin
					bacc_q <= '0;
					for (int k = 0; k < MAX_FEATURES; k++) begin
						wacc_q[k] <= '0;
					end
				end
				ST_GRD_ACC: begin
					wacc_q[jx] <= wacc_q[jx] + prod_asr;
					if (j_last) begin
						bacc_q <= bacc_q + {{(ACC_W-VAL_W){err_q[VAL_W-1]}}, err_q};
					end
				end
				ST_STEP_UPD: begin
					if (j_bias) begin
						bias_q <= bias_q - step;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Weights, dot product, error and divider datapath
	always_ff @(posedge clk) begin
		if (in_acc && (in_cmd == CMD_LOAD_WEIGHT)) begin
			weight_q[in_fi] <= in_val;
		end
		case (state_q)
			ST_CLR:     dot_q <= '0;
			ST_DOT_ACC: dot_q <= dot_q + prod_s1[47:16];
			ST_ERR: begin
				err_q <= dot_q + bias_q - y_rdata;
				dot_q <= '0;
			end
			ST_DIV_INIT: begin
				div_neg_q <= div_src[ACC_W-1];
				div_a_q   <= div_src[ACC_W-1] ? -div_src : div_src;
				rem_q     <= '0;
			end
			ST_DIV_STEP: begin
				rem_q   <= rem_ge ? MCNT_W'(rem_sh - {1'b0, m_q}) : rem_sh[MCNT_W-1:0];
				div_a_q <= {div_a_q[ACC_W-2:0], rem_ge};
			end
			ST_DIV_FIX: begin
				if (div_neg_q) begin
					div_a_q <= -div_a_q;
				end
			end
			ST_STEP_HI: lo_q <= prod_s1[47:0];
			ST_STEP_UPD: begin
				if (!j_bias) begin
					weight_q[jx] <= weight_q[jx] - step;
				end
			end
			default: begin
			end
		endcase
	end

	// Checks
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("input ready while a result is pending");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV_STEP |-> rem_q < m_q)
		else $error("divider remainder out of range");

	a_j_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> j_q <= n_q)
		else $error("parameter index past bias");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("run did not end after bias result");

endmodule
